// File: design/cfd_pkg.sv
`timescale 1ns / 1ps

package cfd_pkg;

    // byte position counter and the captured header/payload prefix
    localparam int IDX_W         = 5;
    localparam int CAPTURE_COUNT = 11;

    typedef enum logic [1:0] {
        ST_CKSUM_ERR = 2'd0,
        ST_REMOTE    = 2'd1,
        ST_PARAM     = 2'd2,
        ST_OTHER     = 2'd3
    } t_frame_status;

    typedef enum logic [1:0] {
        CFG_HEADER  = 2'd0,
        CFG_CTRL_FN = 2'd1,
        CFG_CMD_FN  = 2'd2,
        CFG_PAY_LEN = 2'd3
    } t_cfg_index;

    localparam logic [7:0] CFG_HEADER_RST  = 8'd138;
    localparam logic [7:0] CFG_CTRL_FN_RST = 8'd138;
    localparam logic [7:0] CFG_CMD_FN_RST  = 8'd139;
    localparam logic [7:0] CFG_PAY_LEN_RST = 8'd28;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] ctrl_fn;
        logic [7:0] cmd_fn;
        logic [7:0] pay_len;
    } t_cfg;

    // throttle offset
    localparam logic [15:0] THROTTLE_BIAS = 16'd1000;

    // axis scaling: (18*s - 27000) / 100, truncated toward zero
    localparam int                 AXIS_EXT_W  = 22;
    localparam int                 AXIS_MAG_W  = 20;
    localparam int                 AXIS_OUT_W  = 14;
    localparam logic signed [21:0] AXIS_OFFSET = 22'sd27000;
    // numerator is negative exactly when s is below this
    localparam logic signed [15:0] AXIS_ZERO_RAW = 16'sd1500;
    // ceil(2^27 / 100); exact floor division for magnitudes below 1.86M
    localparam int                 RECIP_W     = 21;
    localparam int                 RECIP_SHIFT = 27;
    localparam logic [20:0]        RECIP_MUL   = 21'd1342178;

    typedef struct packed {
        t_frame_status      status;
        logic [7:0]         command_code;
        logic [15:0]        throttle;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] roll_raw;
        logic signed [15:0] pitch_raw;
    } t_frame_result;

endpackage

// File: design/cfd_frame_track.sv
`timescale 1ns / 1ps

module cfd_frame_track #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_start,
    input  cfd_pkg::t_cfg         i_cfg,
    output logic                  o_last,
    output cfd_pkg::t_frame_result o_result
);

    localparam logic [cfd_pkg::IDX_W-1:0] LAST_IDX = cfd_pkg::IDX_W'(FRAME_BYTES - 1);

    logic [cfd_pkg::IDX_W-1:0] r_idx, n_idx, w_idx;
    logic [7:0]                r_sum, n_sum, w_sum;
    logic [7:0]                r_cap [cfd_pkg::CAPTURE_COUNT];
    logic                      w_hdr_ok;

    // a start flag restarts position and sum on this very word
    always_comb begin
        w_idx  = i_frame_start ? '0 : r_idx;
        w_sum  = i_frame_start ? '0 : r_sum;
        o_last = (w_idx == LAST_IDX);
        n_idx  = o_last ? '0 : w_idx + cfd_pkg::IDX_W'(1);
        n_sum  = o_last ? '0 : w_sum + i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_sum <= '0;
        end else if (i_accept) begin
            r_idx <= n_idx;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cfd_pkg::CAPTURE_COUNT; k++) begin
            if (i_accept && w_idx == cfd_pkg::IDX_W'(k)) begin
                r_cap[k] <= i_rx_byte;
            end
        end
    end

    // on the last word all captured bytes belong to the current frame
    always_comb begin
        w_hdr_ok = (r_cap[0] == i_cfg.header) && (r_cap[2] == i_cfg.pay_len);
        o_result = '0;
        if (w_sum != i_rx_byte) begin
            o_result.status = cfd_pkg::ST_CKSUM_ERR;
        end else if (w_hdr_ok && r_cap[1] == i_cfg.ctrl_fn) begin
            o_result.status    = cfd_pkg::ST_REMOTE;
            o_result.throttle  = {r_cap[3], r_cap[4]} - cfd_pkg::THROTTLE_BIAS;
            o_result.yaw_raw   = $signed({r_cap[5], r_cap[6]});
            o_result.roll_raw  = $signed({r_cap[7], r_cap[8]});
            o_result.pitch_raw = $signed({r_cap[9], r_cap[10]});
        end else if (w_hdr_ok && r_cap[1] == i_cfg.cmd_fn) begin
            o_result.status       = cfd_pkg::ST_PARAM;
            o_result.command_code = r_cap[3];
        end else begin
            o_result.status = cfd_pkg::ST_OTHER;
        end
    end

endmodule

// File: design/cfd_axis_scale.sv
`timescale 1ns / 1ps

module cfd_axis_scale (
    input  logic                                   i_clk,
    input  logic                                   i_load_mag,
    input  logic                                   i_load_out,
    input  logic                                   i_zero,
    input  logic signed [15:0]                     i_raw,
    output logic signed [cfd_pkg::AXIS_OUT_W-1:0]  o_scaled
);

    localparam int PROD_W = cfd_pkg::AXIS_MAG_W + cfd_pkg::RECIP_W;

    logic signed [cfd_pkg::AXIS_EXT_W-1:0] w_ext, w_x18, w_pos, w_negv;
    logic                                  w_neg;
    logic [cfd_pkg::AXIS_MAG_W-1:0]        n_mag, r_mag;
    logic                                  r_neg, r_zero;
    logic [PROD_W-1:0]                     w_prod;
    logic [cfd_pkg::AXIS_OUT_W-1:0]        w_q;
    logic signed [cfd_pkg::AXIS_OUT_W-1:0] n_out, r_out;

    // stage A: magnitude of 18*s - 27000, both signs computed side by side
    always_comb begin
        w_ext  = cfd_pkg::AXIS_EXT_W'(i_raw);
        w_x18  = (w_ext <<< 4) + (w_ext <<< 1);
        w_pos  = w_x18 - cfd_pkg::AXIS_OFFSET;
        w_negv = cfd_pkg::AXIS_OFFSET - w_x18;
        w_neg  = (i_raw < cfd_pkg::AXIS_ZERO_RAW);
        n_mag  = w_neg ? w_negv[cfd_pkg::AXIS_MAG_W-1:0] : w_pos[cfd_pkg::AXIS_MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load_mag) begin
            r_mag  <= n_mag;
            r_neg  <= w_neg;
            r_zero <= i_zero;
        end
    end

    // stage B: divide by 100 through a reciprocal multiply, then restore sign
    always_comb begin
        w_prod = PROD_W'(r_mag) * PROD_W'(cfd_pkg::RECIP_MUL);
        w_q    = w_prod[cfd_pkg::RECIP_SHIFT +: cfd_pkg::AXIS_OUT_W];
        if (r_zero) begin
            n_out = '0;
        end else if (r_neg) begin
            n_out = -$signed(w_q);
        end else begin
            n_out = $signed(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_out <= n_out;
        end
    end

    assign o_scaled = r_out;

endmodule

// File: design/command_frame_decoder.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle, sustained; ready drops only under output stall.
// The three-stage result pipeline (classify, axis magnitude, reciprocal multiply)
// holds up to three results, the output register included, before the input stalls.
// Reset (synchronous, active low) clears byte position, running sum, pipeline
// valids and restores the configuration registers to their defaults.

module command_frame_decoder #(
    parameter int FRAME_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_frame_status,
    output logic [7:0]         o_command_code,
    output logic signed [15:0] o_throttle_out,
    output logic signed [13:0] o_yaw_out,
    output logic signed [13:0] o_roll_out,
    output logic signed [13:0] o_pitch_out,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    cfd_pkg::t_cfg          r_cfg;
    cfd_pkg::t_frame_result w_result, r_s1;
    logic                   w_last, w_accept;

    // pipeline valids and per-stage advance
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic w_out_adv, w_s2_adv, w_s1_adv;

    // side fields that ride along with the axis pipeline
    cfd_pkg::t_frame_status r_s2_status, r_out_status;
    logic [7:0]             r_s2_cmd, r_out_cmd;
    logic [15:0]            r_s2_thr, r_out_thr;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header  <= cfd_pkg::CFG_HEADER_RST;
            r_cfg.ctrl_fn <= cfd_pkg::CFG_CTRL_FN_RST;
            r_cfg.cmd_fn  <= cfd_pkg::CFG_CMD_FN_RST;
            r_cfg.pay_len <= cfd_pkg::CFG_PAY_LEN_RST;
        end else if (i_cfg_we) begin
            case (cfd_pkg::t_cfg_index'(i_cfg_index))
                cfd_pkg::CFG_HEADER:  r_cfg.header  <= i_cfg_data;
                cfd_pkg::CFG_CTRL_FN: r_cfg.ctrl_fn <= i_cfg_data;
                cfd_pkg::CFG_CMD_FN:  r_cfg.cmd_fn  <= i_cfg_data;
                cfd_pkg::CFG_PAY_LEN: r_cfg.pay_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: each stage moves when the one after it can take a word.
    // Non-final words only touch the tracker state, but share the stall
    // so the pipeline never drops a result.
    // ---------------------------------------------------------------
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_s2_adv   = !r_s2_valid || w_out_adv;
    assign w_s1_adv   = !r_s1_valid || w_s2_adv;
    assign o_in_ready = w_s1_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    cfd_frame_track #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_cfg         (r_cfg),
        .o_last        (w_last),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= w_accept && w_last;
            end
            if (w_s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // stage 1: classified frame
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_accept && w_last) begin
            r_s1 <= w_result;
        end
    end

    // stage 2 and output stage for the non-axis fields
    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s1_valid) begin
            r_s2_status <= r_s1.status;
            r_s2_cmd    <= r_s1.command_code;
            r_s2_thr    <= r_s1.throttle;
        end
        if (w_out_adv && r_s2_valid) begin
            r_out_status <= r_s2_status;
            r_out_cmd    <= r_s2_cmd;
            r_out_thr    <= r_s2_thr;
        end
    end

    // axes are forced to zero unless the frame is remote control
    cfd_axis_scale u_yaw (
        .i_clk      (i_clk),
        .i_load_mag (w_s2_adv && r_s1_valid),
        .i_load_out (w_out_adv && r_s2_valid),
        .i_zero     (r_s1.status != cfd_pkg::ST_REMOTE),
        .i_raw      (r_s1.yaw_raw),
        .o_scaled   (o_yaw_out)
    );

    cfd_axis_scale u_roll (
        .i_clk      (i_clk),
        .i_load_mag (w_s2_adv && r_s1_valid),
        .i_load_out (w_out_adv && r_s2_valid),
        .i_zero     (r_s1.status != cfd_pkg::ST_REMOTE),
        .i_raw      (r_s1.roll_raw),
        .o_scaled   (o_roll_out)
    );

    cfd_axis_scale u_pitch (
        .i_clk      (i_clk),
        .i_load_mag (w_s2_adv && r_s1_valid),
        .i_load_out (w_out_adv && r_s2_valid),
        .i_zero     (r_s1.status != cfd_pkg::ST_REMOTE),
        .i_raw      (r_s1.pitch_raw),
        .o_scaled   (o_pitch_out)
    );

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_out_status;
    assign o_command_code = r_out_cmd;
    assign o_throttle_out = $signed(r_out_thr);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_nonremote_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_status != cfd_pkg::ST_REMOTE) |->
        (o_throttle_out == 16'sd0 && o_yaw_out == 14'sd0 &&
         o_roll_out == 14'sd0 && o_pitch_out == 14'sd0))
        else $error("axis or throttle nonzero on non remote frame");

    a_cmd_only_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_status != cfd_pkg::ST_PARAM) |->
        (o_command_code == 8'd0))
        else $error("command code nonzero outside parameter frame");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_yaw_out >= -14'sd6169 && o_yaw_out <= 14'sd5628 &&
         o_roll_out >= -14'sd6169 && o_roll_out <= 14'sd5628 &&
         o_pitch_out >= -14'sd6169 && o_pitch_out <= 14'sd5628))
        else $error("scaled axis out of range");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !o_in_ready) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stage 1 result lost under stall");

endmodule

// File: test/tb_command_frame_decoder.sv
`timescale 1ns / 1ps

module tb_command_frame_decoder;

    localparam int FRAME_LEN   = 32;    // bytes per frame, last one is the checksum
    localparam int HEAD_BYTES  = 11;    // header, function, length and payload 3..10
    localparam int DRAIN_WAIT  = 8;     // result passes stage 1, stage 2 and the output register after the last word
    localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
    localparam int PHASE_WORDS = 20;
    localparam int HOLD_CYCLES = 400;   // long output stall, fills the result pipeline

    typedef struct packed {
        cfd_pkg::t_frame_status status;
        logic [7:0]             cmd;
        logic [15:0]            throttle;
        logic [13:0]            yaw;
        logic [13:0]            roll;
        logic [13:0]            pitch;
    } t_result;

    // one input word as queued for the driver; a frame's last word may carry
    // a hand-written result that replaces the computed one
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       pinned;
        t_result    pin;
    } t_word;

    // directed frame: optional aborted prefix, then one full frame
    typedef struct {
        int          junk;
        bit          start;
        logic [7:0]  hdr;
        logic [7:0]  fn;
        logic [7:0]  len;
        logic [63:0] pay;     // frame bytes 3..10, byte 3 in the top bits
        logic [7:0]  fill;    // bytes 11..30
        bit          bad_sum;
        bit          pinned;
        t_result     pin;
    } t_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [7:0]          i_rx_byte     = '0;
    logic                i_frame_start = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [1:0]          o_frame_status;
    logic [7:0]          o_command_code;
    logic signed [15:0]  o_throttle_out;
    logic signed [13:0]  o_yaw_out;
    logic signed [13:0]  o_roll_out;
    logic signed [13:0]  o_pitch_out;
    logic                i_cfg_we      = 1'b0;
    cfd_pkg::t_cfg_index i_cfg_index   = cfd_pkg::CFG_HEADER;
    logic [7:0]          i_cfg_data    = '0;

    // side info of the word on the bus, set together with the payload
    logic    word_pinned = 1'b0;
    t_result word_pin    = '0;

    // decoder state as predicted
    logic [4:0] frame_pos = '0;
    logic [7:0] frame_sum = '0;
    logic [7:0] frame_head [HEAD_BYTES];
    logic [7:0] cfg_hdr   = cfd_pkg::CFG_HEADER_RST;
    logic [7:0] cfg_ctrl  = cfd_pkg::CFG_CTRL_FN_RST;
    logic [7:0] cfg_cmd   = cfd_pkg::CFG_CMD_FN_RST;
    logic [7:0] cfg_len   = cfd_pkg::CFG_PAY_LEN_RST;

    t_result    pending_results [$];
    t_word      word_q [$];
    t_row       rows [$];
    logic [7:0] frame_buf [FRAME_LEN];
    bit         word_taken     = 1'b0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_cnt       = 0;
    int         errors         = 0;
    int         words_queued   = 0;
    int         quiet_cycles   = 0;

    command_frame_decoder #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_status(o_frame_status),
        .o_command_code(o_command_code),
        .o_throttle_out(o_throttle_out),
        .o_yaw_out     (o_yaw_out),
        .o_roll_out    (o_roll_out),
        .o_pitch_out   (o_pitch_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // (18*s - 27000)/100 on a big-endian signed 16-bit stick value;
    // int division truncates toward zero, as the block must
    function automatic logic [13:0] axis_scale(logic [7:0] hi, logic [7:0] lo);
        int s;
        int v;
        s = int'($signed({hi, lo}));
        v = (s * 18 - 27000) / 100;
        return v[13:0];
    endfunction

    // advance the frame state by one accepted word; returns 1 on a frame's
    // last byte with the decoded result in r
    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       output t_result r);
        r = '0;
        if (start) begin
            frame_pos = '0;
            frame_sum = '0;
        end
        if (frame_pos < HEAD_BYTES) frame_head[frame_pos] = b;
        if (frame_pos < FRAME_LEN - 1) begin
            frame_sum += b;
            frame_pos += 5'd1;
            return 1'b0;
        end
        if (frame_sum != b) begin
            r.status = cfd_pkg::ST_CKSUM_ERR;
        end else if (frame_head[0] == cfg_hdr && frame_head[1] == cfg_ctrl &&
                     frame_head[2] == cfg_len) begin
            // remote control wins when both function codes match
            r.status   = cfd_pkg::ST_REMOTE;
            r.throttle = {frame_head[3], frame_head[4]} - cfd_pkg::THROTTLE_BIAS;
            r.yaw      = axis_scale(frame_head[5], frame_head[6]);
            r.roll     = axis_scale(frame_head[7], frame_head[8]);
            r.pitch    = axis_scale(frame_head[9], frame_head[10]);
        end else if (frame_head[0] == cfg_hdr && frame_head[1] == cfg_cmd &&
                     frame_head[2] == cfg_len) begin
            r.status = cfd_pkg::ST_PARAM;
            r.cmd    = frame_head[3];
        end else begin
            r.status = cfd_pkg::ST_OTHER;
        end
        frame_pos = '0;
        frame_sum = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // everything the bus does is sampled here, at the rising edge
    always @(posedge i_clk) begin : monitor
        t_result predicted;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cfd_pkg::CFG_HEADER:  cfg_hdr  = i_cfg_data;
                    cfd_pkg::CFG_CTRL_FN: cfg_ctrl = i_cfg_data;
                    cfd_pkg::CFG_CMD_FN:  cfg_cmd  = i_cfg_data;
                    cfd_pkg::CFG_PAY_LEN: cfg_len  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                word_taken = 1'b1;
                if (decode_byte(i_rx_byte, i_frame_start, predicted))
                    pending_results.push_back(word_pinned ? word_pin : predicted);
            end
            if (o_out_valid && i_out_ready) begin
                got.status   = cfd_pkg::t_frame_status'(o_frame_status);
                got.cmd      = o_command_code;
                got.throttle = o_throttle_out;
                got.yaw      = o_yaw_out;
                got.roll     = o_roll_out;
                got.pitch    = o_pitch_out;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with no frame pending, %s %0d",
                             $time, "expected none, got status", o_frame_status);
                end else begin
                    want = pending_results.pop_front();
                    check_field("frame_status", 16'(want.status), 16'(got.status));
                    check_field("command_code", 16'(want.cmd), 16'(got.cmd));
                    check_field("throttle_out", want.throttle, got.throttle);
                    check_field("yaw_out", 16'(want.yaw), 16'(got.yaw));
                    check_field("roll_out", 16'(want.roll), 16'(got.roll));
                    check_field("pitch_out", 16'(want.pitch), 16'(got.pitch));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // bus drivers, all on the falling edge
    // ------------------------------------------------------------------

    // holds a word until taken, then either idles or presents the next one
    initial begin : word_driver
        t_word w;
        forever begin
            @(negedge i_clk);
            if (!i_in_valid || word_taken) begin
                word_taken = 1'b0;
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = word_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_rx_byte     <= w.data;
                    i_frame_start <= w.start;
                    word_pinned   <= w.pinned;
                    word_pin      <= w.pin;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side; hold_cnt forces a long stall when set
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                i_out_ready <= 1'b0;
                hold_cnt--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("command_frame_decoder: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void queue_word(logic [7:0] data, logic start, logic pinned,
                                       t_result pin);
        t_word w;
        w.data   = data;
        w.start  = start;
        w.pinned = pinned;
        w.pin    = pin;
        word_q.push_back(w);
        words_queued++;
    endfunction

    function automatic void load_frame(logic [7:0] hdr, logic [7:0] fn, logic [7:0] len,
                                       logic [63:0] pay, logic [7:0] fill, bit rand_fill);
        frame_buf[0] = hdr;
        frame_buf[1] = fn;
        frame_buf[2] = len;
        for (int k = 0; k < 8; k++) frame_buf[3 + k] = pay[63 - 8 * k -: 8];
        for (int k = HEAD_BYTES; k < FRAME_LEN - 1; k++)
            frame_buf[k] = rand_fill ? 8'($urandom) : fill;
    endfunction

    // append the checksum (optionally broken) and queue the whole frame
    function automatic void queue_frame(bit start, bit bad, bit pinned, t_result pin);
        logic [7:0] sum;
        sum = '0;
        for (int k = 0; k < FRAME_LEN - 1; k++) sum += frame_buf[k];
        frame_buf[FRAME_LEN - 1] = bad ? sum + 8'($urandom_range(255, 1)) : sum;
        for (int k = 0; k < FRAME_LEN; k++)
            queue_word(frame_buf[k], start && (k == 0), pinned && (k == FRAME_LEN - 1), pin);
    endfunction

    // random bytes; lead_start marks the first as a frame start (aborted frame)
    function automatic void queue_noise(int n, bit lead_start, int start_pct);
        for (int k = 0; k < n; k++)
            queue_word(8'($urandom), (lead_start && k == 0) || ($urandom_range(99) < start_pct),
                       1'b0, '0);
    endfunction

    // stick/throttle values biased to the corners of the scaling
    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h05DC;  // axis exactly zero
            5: return 16'h05DB;  // small negative numerator, truncates to zero
            6: return 16'h03E8;  // throttle exactly zero
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly frames the current settings accept, with some wrong header,
    // function or length bytes and some broken checksums
    function automatic void queue_good_frame(bit start);
        logic [7:0] hdr;
        logic [7:0] fn;
        logic [7:0] len;
        int         sel;
        hdr = ($urandom_range(9) != 0) ? cfg_hdr : 8'($urandom);
        sel = $urandom_range(99);
        fn  = (sel < 45) ? cfg_ctrl : (sel < 85) ? cfg_cmd : 8'($urandom);
        len = ($urandom_range(9) != 0) ? cfg_len : 8'($urandom);
        load_frame(hdr, fn, len, {pick_value(), pick_value(), pick_value(), pick_value()},
                   8'h00, 1'b1);
        queue_frame(start, $urandom_range(99) < 12, 1'b0, '0);
    endfunction

    function automatic t_result mk_result(cfd_pkg::t_frame_status status, logic [7:0] cmd,
                                          logic [15:0] thr, logic [13:0] yaw,
                                          logic [13:0] roll, logic [13:0] pitch);
        t_result r;
        r.status   = status;
        r.cmd      = cmd;
        r.throttle = thr;
        r.yaw      = yaw;
        r.roll     = roll;
        r.pitch    = pitch;
        return r;
    endfunction

    function automatic t_row make_row(int junk, bit start, logic [7:0] hdr, logic [7:0] fn,
                                      logic [7:0] len, logic [63:0] pay, logic [7:0] fill,
                                      bit bad, bit pinned, t_result pin);
        t_row row;
        row.junk    = junk;
        row.start   = start;
        row.hdr     = hdr;
        row.fn      = fn;
        row.len     = len;
        row.pay     = pay;
        row.fill    = fill;
        row.bad_sum = bad;
        row.pinned  = pinned;
        row.pin     = pin;
        return row;
    endfunction

    function automatic void queue_row(t_row row);
        if (row.junk > 0) queue_noise(row.junk, 1'b1, 0);
        load_frame(row.hdr, row.fn, row.len, row.pay, row.fill, 1'b0);
        queue_frame(row.start || row.junk > 0, row.bad_sum, row.pinned, row.pin);
    endfunction

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    task automatic write_cfg(cfd_pkg::t_cfg_index idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] hdr, logic [7:0] ctrl, logic [7:0] cmd,
                              logic [7:0] len);
        write_cfg(cfd_pkg::CFG_HEADER, hdr);
        write_cfg(cfd_pkg::CFG_CTRL_FN, ctrl);
        write_cfg(cfd_pkg::CFG_CMD_FN, cmd);
        write_cfg(cfd_pkg::CFG_PAY_LEN, len);
    endtask

    // wait for every queued word to go in and every result to come out,
    // then let the pipeline settle
    task automatic settle();
        while (word_q.size() != 0 || (i_in_valid && !word_taken) ||
               pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int         pick;
        int         target;
        bit         need_start;
        logic [7:0] rnd_fn;
        t_result    none;

        none = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames against the reset settings
        // hdr/ctrl/cmd/len at reset: 8A / 8A / 8B / 1C
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'h03E8_05DC_05DC_05DC, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_REMOTE, 8'h00, 16'sd0, 14'sd0, 14'sd0, 14'sd0)));
        // throttle floor, stick extremes, negative fraction truncated toward zero
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'h0000_7FFF_8000_0001, 8'h5A, 0, 1,
            mk_result(cfd_pkg::ST_REMOTE, 8'h00, -16'sd1000, 14'sd5628, -14'sd6168,
                      -14'sd269)));
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'hFFFF_0000_FFFF_05DB, 8'hA5, 0, 1,
            mk_result(cfd_pkg::ST_REMOTE, 8'h00, -16'sd1001, -14'sd270, -14'sd270,
                      14'sd0)));
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CMD_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'hA5FF_FFFF_FFFF_FFFF, 8'h11, 0, 1,
            mk_result(cfd_pkg::ST_PARAM, 8'hA5, '0, '0, '0, '0)));
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CMD_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'hFF00_1234_5678_9ABC, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_PARAM, 8'hFF, '0, '0, '0, '0)));
        // header, length, function wrong in turn
        rows.push_back(make_row(0, 1, 8'h00, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'h03E8_05DC_05DC_05DC, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_OTHER, '0, '0, '0, '0, '0)));
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            8'hFF, 64'h03E8_05DC_05DC_05DC, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_OTHER, '0, '0, '0, '0, '0)));
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, 8'h00,
            cfd_pkg::CFG_PAY_LEN_RST, 64'hA5A5_A5A5_A5A5_A5A5, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_OTHER, '0, '0, '0, '0, '0)));
        // broken checksum zeroes everything
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'h0000_7FFF_8000_0001, 8'h33, 1, 1,
            mk_result(cfd_pkg::ST_CKSUM_ERR, '0, '0, '0, '0, '0)));
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CMD_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'hA500_0000_0000_0000, 8'h33, 1, 1,
            mk_result(cfd_pkg::ST_CKSUM_ERR, '0, '0, '0, '0, '0)));
        // restart in the middle of a frame
        rows.push_back(make_row(10, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, {$urandom, $urandom}, 8'h00, 0, 0, none));
        // no start flag: the byte after a frame is byte 0 anyway
        rows.push_back(make_row(0, 0, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CMD_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, {$urandom, $urandom}, 8'h77, 0, 0, none));
        // all-ones payload, the checksum wraps many times
        rows.push_back(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0, 1,
            mk_result(cfd_pkg::ST_REMOTE, 8'h00, -16'sd1001, -14'sd270, -14'sd270,
                      -14'sd270)));
        // restart on what would have been the checksum byte
        rows.push_back(make_row(31, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, {$urandom, $urandom}, 8'h00, 0, 0, none));
        rows.push_back(make_row(0, 1, 8'h00, 8'h00, 8'h00, 64'h0, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_OTHER, '0, '0, '0, '0, '0)));
        rows.push_back(make_row(0, 0, 8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0, 1,
            mk_result(cfd_pkg::ST_OTHER, '0, '0, '0, '0, '0)));
        foreach (rows[k]) queue_row(rows[k]);
        settle();

        // both function codes equal: remote control must win
        write_cfg(cfd_pkg::CFG_CMD_FN, cfd_pkg::CFG_CTRL_FN_RST);
        queue_row(make_row(0, 1, cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
            cfd_pkg::CFG_PAY_LEN_RST, 64'h03E8_05DC_05DC_05DC, 8'h00, 0, 1,
            mk_result(cfd_pkg::ST_REMOTE, 8'h00, 16'sd0, 14'sd0, 14'sd0, 14'sd0)));

        // random phases, each with its own settings and flow pattern
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            rnd_fn = 8'($urandom);
            case (phase)
                0: set_config(cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
                              cfd_pkg::CFG_CMD_FN_RST, cfd_pkg::CFG_PAY_LEN_RST);
                1: set_config(8'h00, 8'h00, 8'hFF, 8'h00);
                2: set_config(8'hFF, 8'hFF, 8'h00, 8'hFF);
                3: set_config(8'($urandom), rnd_fn, rnd_fn, 8'($urandom));
                4: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                default: set_config(cfd_pkg::CFG_HEADER_RST, cfd_pkg::CFG_CTRL_FN_RST,
                                    cfd_pkg::CFG_CMD_FN_RST, cfd_pkg::CFG_PAY_LEN_RST);
            endcase
            @(posedge i_clk);
            case (phase)
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                5:       begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase

            // output blocked while frames keep coming: the result pipeline
            // fills and the last byte of a later frame has to wait
            if (phase == 4) begin
                hold_cnt = HOLD_CYCLES;
                repeat (6) queue_good_frame(1'b1);
            end

            need_start = 1'b1;
            target = words_queued + PHASE_WORDS;
            while (words_queued < target) begin
                pick = $urandom_range(99);
                if (pick < 72) begin
                    queue_good_frame(need_start || $urandom_range(4) != 0);
                    need_start = 1'b0;
                end else if (pick < 86) begin
                    queue_noise($urandom_range(31, 1), 1'b1, 0);
                    need_start = 1'b1;
                end else begin
                    queue_noise($urandom_range(40, 1), 1'b0, 12);
                    need_start = 1'b1;
                end
            end
            // close on a frame boundary before the settings change
            queue_good_frame(1'b1);
        end
        settle();

        if (errors == 0)
            $display("command_frame_decoder: match");
        else
            $display("command_frame_decoder: mismatch");
        $finish;
    end

endmodule
